// ----- hw/rtl/pvkf_pkg.sv -----
// package for the position/velocity kalman filter
// holds word constants, a saturation helper and the controller command types
package pvkf_pkg;
    localparam int WordWidth = 32;
    localparam int FracBits  = 16;
    localparam int CfgWidth  = 31;
    localparam int CfgIdxW   = 2;

    localparam logic signed [31:0] WMax = 32'sh7fffffff;
    localparam logic signed [31:0] WMin = 32'sh80000000;
    localparam logic signed [31:0] One  = 32'sd65536;

    localparam logic [CfgIdxW-1:0] RegPosNoise = 2'd0;
    localparam logic [CfgIdxW-1:0] RegVelNoise = 2'd1;
    localparam logic [CfgIdxW-1:0] RegMeasVar  = 2'd2;
    localparam logic [CfgIdxW-1:0] RegTimeStep = 2'd3;

    typedef logic signed [31:0] t_word;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_P_M1, ST_P_M2, ST_P_M3, ST_P_M4, ST_P_WB,
        ST_U_DIV0, ST_U_DIV1, ST_U_INNOV,
        ST_U_M1, ST_U_M2, ST_U_M3, ST_U_M4, ST_U_M5, ST_U_M6, ST_U_WB,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_state step;
        logic   mul_go;
        logic   div_go;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
    } t_status;

    function automatic t_word sat64(input logic signed [63:0] v);
        if (v > 64'(WMax)) begin
            sat64 = WMax;
        end else if (v < 64'(WMin)) begin
            sat64 = WMin;
        end else begin
            sat64 = v[31:0];
        end
    endfunction
endpackage

// ----- hw/rtl/pvkf_if.sv -----
// valid/ready channel interface with generic payload
// depends on nothing
interface pvkf_if #(parameter int PW = 33) (input logic i_clk);
    logic          valid;
    logic          ready;
    logic [PW-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/pvkf_ctrl.sv -----
// controller state machine for the filter
// depends on pvkf_pkg
module pvkf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_req_type,
    input  logic               i_out_taken,
    input  pvkf_pkg::t_status  i_status,
    output pvkf_pkg::t_cmd     o_cmd,
    output logic               o_idle,
    output logic               o_out_valid
);
    import pvkf_pkg::*;
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    function automatic t_state mstep(input t_state cur, input t_state nxt, input logic d);
        mstep = d ? nxt : cur;
    endfunction

    always_comb begin
        n_state = r_state;
        o_cmd.step = r_state;
        o_cmd.mul_go = 1'b0;
        o_cmd.div_go = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = i_req_type ? ST_U_DIV0 : ST_P_M1;
                end
            end
            ST_P_M1: n_state = mstep(r_state, ST_P_M2, i_status.mul_done);
            ST_P_M2: n_state = mstep(r_state, ST_P_M3, i_status.mul_done);
            ST_P_M3: n_state = mstep(r_state, ST_P_M4, i_status.mul_done);
            ST_P_M4: n_state = mstep(r_state, ST_P_WB, i_status.mul_done);
            ST_P_WB: n_state = ST_OUT;
            ST_U_DIV0: n_state = mstep(r_state, ST_U_DIV1, i_status.div_done);
            ST_U_DIV1: n_state = mstep(r_state, ST_U_INNOV, i_status.div_done);
            ST_U_INNOV: n_state = ST_U_M1;
            ST_U_M1: n_state = mstep(r_state, ST_U_M2, i_status.mul_done);
            ST_U_M2: n_state = mstep(r_state, ST_U_M3, i_status.mul_done);
            ST_U_M3: n_state = mstep(r_state, ST_U_M4, i_status.mul_done);
            ST_U_M4: n_state = mstep(r_state, ST_U_M5, i_status.mul_done);
            ST_U_M5: n_state = mstep(r_state, ST_U_M6, i_status.mul_done);
            ST_U_M6: n_state = mstep(r_state, ST_U_WB, i_status.mul_done);
            ST_U_WB: n_state = ST_OUT;
            ST_OUT: begin
                if (i_out_taken) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        o_cmd.mul_go = (n_state != r_state) &&
            (n_state == ST_P_M1 || n_state == ST_P_M2 || n_state == ST_P_M3 ||
             n_state == ST_P_M4 || n_state == ST_U_M1 || n_state == ST_U_M2 ||
             n_state == ST_U_M3 || n_state == ST_U_M4 || n_state == ST_U_M5 ||
             n_state == ST_U_M6);
        o_cmd.div_go = (n_state != r_state) &&
            (n_state == ST_U_DIV0 || n_state == ST_U_DIV1);
        o_idle = (r_state == ST_IDLE);
        o_out_valid = (r_state == ST_OUT);
    end

    a_out_from_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && !$past(r_state == ST_OUT)) |->
        ($past(r_state == ST_P_WB) || $past(r_state == ST_U_WB)))
        else $error("result shown without writeback");
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && !i_out_taken) |=> r_state == ST_OUT)
        else $error("result dropped");
    a_go_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.mul_go && o_cmd.div_go))
        else $error("two units started together");
endmodule

// ----- hw/rtl/pvkf_dp.sv -----
// datapath: state registers, a sequenced 32x32 multiplier and a radix-2
// restoring divider; depends on pvkf_pkg
module pvkf_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pvkf_pkg::t_cmd            i_cmd,
    input  logic                      i_load,
    input  logic signed [31:0]        i_meas,
    input  logic                      i_cfg_we,
    input  logic [pvkf_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [pvkf_pkg::CfgWidth-1:0] i_cfg_data,
    output pvkf_pkg::t_status         o_status,
    output logic signed [31:0]        o_pos,
    output logic signed [31:0]        o_vel
);
    import pvkf_pkg::*;

    t_word r_pos, r_vel, r_pp, r_pv, r_vp, r_vv, r_z;
    logic [CfgWidth-1:0] r_qp, r_qv, r_rm, r_dt;
    t_word r_t0, r_t1, r_t2, r_t3, r_k0, r_k1, r_y, r_omk;

    // multiplier operands, product stage and result
    t_word r_ma, r_mb;
    logic signed [63:0] r_prod;
    logic r_mbusy, r_mph;
    t_word mres;

    // divider
    logic [63:0] r_rem;
    logic [47:0] r_dnum;
    logic [32:0] r_dden;
    logic [47:0] r_quo;
    logic [5:0]  r_dcnt;
    logic r_dbusy, r_dneg, r_dzero;
    logic signed [32:0] s_full;
    t_word dres;

    assign s_full = 33'(r_pp) + 33'({1'b0, r_rm});
    assign o_pos = r_pos;
    assign o_vel = r_vel;

    always_comb begin
        logic signed [63:0] sh;
        sh = r_prod >>> FracBits;
        mres = sat64(sh);
        if (r_dneg) begin
            dres = sat64(-$signed({16'd0, r_quo}));
        end else begin
            dres = sat64($signed({16'd0, r_quo}));
        end
        if (r_dzero) begin
            dres = '0;
        end
    end

    assign o_status.mul_done = r_mbusy && r_mph;
    assign o_status.div_done = r_dbusy && (r_dcnt == 6'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_mph <= 1'b0;
        end else if (i_cmd.mul_go) begin
            r_mbusy <= 1'b1;
            r_mph <= 1'b0;
        end else if (r_mbusy && !r_mph) begin
            r_mph <= 1'b1;
        end else begin
            r_mbusy <= 1'b0;
            r_mph <= 1'b0;
        end
        r_prod <= 64'(r_ma) * 64'(r_mb);
    end

    // divider: |num|<<16 over s, truncated toward zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_dcnt <= '0;
        end else if (i_cmd.div_go) begin
            r_dbusy <= 1'b1;
            r_dcnt <= 6'd48;
        end else if (r_dbusy && r_dcnt != 6'd0) begin
            r_dcnt <= r_dcnt - 6'd1;
        end else begin
            r_dbusy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [63:0] trial;
        t_word num;
        if (i_cmd.div_go) begin
            if (i_cmd.step == ST_U_DIV0) begin
                num = r_vp;
            end else begin
                num = r_pp;
            end
            r_dneg <= num[31];
            r_dzero <= (s_full <= 0);
            r_dnum <= {(num[31] ? 32'(-num) : 32'(num)), 16'd0};
            r_dden <= s_full;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_dbusy && r_dcnt != 6'd0) begin
            trial = {r_rem[62:0], r_dnum[47]};
            r_dnum <= {r_dnum[46:0], 1'b0};
            if (!r_dzero && trial >= 64'(r_dden)) begin
                r_rem <= trial - 64'(r_dden);
                r_quo <= {r_quo[46:0], 1'b1};
            end else begin
                r_rem <= trial;
                r_quo <= {r_quo[46:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_vel <= '0;
            r_pp <= One;
            r_pv <= '0;
            r_vp <= '0;
            r_vv <= One;
            r_qp <= 31'd66;
            r_qv <= 31'd66;
            r_rm <= 31'd65536;
            r_dt <= 31'd655;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    RegPosNoise: r_qp <= i_cfg_data;
                    RegVelNoise: r_qv <= i_cfg_data;
                    RegMeasVar:  r_rm <= i_cfg_data;
                    RegTimeStep: r_dt <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_load) begin
                r_z <= i_meas;
            end
            // operand set-up on go, result capture on done
            if (i_cmd.mul_go) begin
                case (i_cmd.step)
                    ST_IDLE: begin
                        r_ma <= t_word'({1'b0, r_dt}); r_mb <= r_vv;
                    end
                    ST_P_M1: begin
                        r_ma <= t_word'({1'b0, r_dt}); r_mb <= r_vp;
                    end
                    ST_P_M2: begin
                        r_ma <= t_word'({1'b0, r_dt}); r_mb <= r_t0;
                    end
                    ST_P_M3: begin
                        r_ma <= t_word'({1'b0, r_dt}); r_mb <= r_vel;
                    end
                    ST_U_INNOV: begin
                        r_ma <= r_k0; r_mb <= sat64(64'(r_z) - 64'(r_pos));
                    end
                    ST_U_M1: begin
                        r_ma <= r_k1; r_mb <= r_y;
                    end
                    ST_U_M2: begin
                        r_ma <= r_omk; r_mb <= r_pp;
                    end
                    ST_U_M3: begin
                        r_ma <= r_omk; r_mb <= r_pv;
                    end
                    ST_U_M4: begin
                        r_ma <= r_k1; r_mb <= r_pp;
                    end
                    default: begin
                        r_ma <= r_k1; r_mb <= r_pv;
                    end
                endcase
            end
            if (o_status.mul_done) begin
                case (i_cmd.step)
                    // dt*vv -> p01, p10
                    ST_P_M1: begin
                        r_t0 <= sat64(64'(r_pv) + 64'(mres));
                        r_t1 <= sat64(64'(r_vp) + 64'(mres));
                    end
                    ST_P_M2: r_t2 <= mres;
                    ST_P_M3: r_t2 <= sat64(64'(r_pp) + 64'(r_t2) + 64'(mres)
                                          + 64'({1'b0, r_qp}));
                    ST_P_M4: r_t3 <= sat64(64'(r_pos) + 64'(mres));
                    ST_U_M1: r_t0 <= sat64(64'(r_pos) + 64'(mres));
                    ST_U_M2: r_t1 <= sat64(64'(r_vel) + 64'(mres));
                    ST_U_M3: r_t2 <= mres;
                    ST_U_M4: r_t3 <= mres;
                    ST_U_M5: r_y <= sat64(64'(r_vp) - 64'(mres));
                    ST_U_M6: r_omk <= sat64(64'(r_vv) - 64'(mres));
                    default: ;
                endcase
            end
            if (o_status.div_done) begin
                if (i_cmd.step == ST_U_DIV0) begin
                    r_k0 <= dres;
                end else begin
                    r_k1 <= dres;
                end
            end
            if (i_cmd.step == ST_U_INNOV) begin
                r_y <= sat64(64'(r_z) - 64'(r_pos));
                r_omk <= sat64(64'(One) - 64'(r_k0));
            end
            if (i_cmd.step == ST_P_WB) begin
                r_pp <= r_t2;
                r_pv <= r_t0;
                r_vp <= r_t1;
                r_vv <= sat64(64'(r_vv) + 64'({1'b0, r_qv}));
                r_pos <= r_t3;
            end
            if (i_cmd.step == ST_U_WB) begin
                r_pos <= r_t0;
                r_vel <= r_t1;
                r_pp <= r_t2;
                r_pv <= r_t3;
                r_vp <= r_y;
                r_vv <= r_omk;
            end
        end
    end

    a_mul_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_mbusy) |=> r_mph)
        else $error("multiplier phase slip");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_go |=> (r_dbusy && r_dcnt == 6'd48))
        else $error("divider start slip");
    a_dt_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mul_go |=> !$isunknown(r_ma))
        else $error("multiplier operand unknown");
endmodule

// ----- hw/rtl/position_velocity_kalman_filter.sv -----
// Two-state Kalman filter, one request in flight. A predict runs four products on the
// sequenced multiplier and a write-back; an update runs two 48-step radix-2 gain
// divisions, an innovation step, six products and a write-back. The result is held
// until taken and the next transaction is accepted from the cycle after. Depends on
// pvkf_pkg, pvkf_if, pvkf_ctrl and pvkf_dp.
module position_velocity_kalman_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pvkf_if.sink        in_ch,
    pvkf_if.source      out_ch,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data
);
    import pvkf_pkg::*;
    t_cmd    cmd;
    t_status status;
    logic idle, out_valid, start;
    logic signed [31:0] pos, vel;

    assign in_ch.ready = idle;
    assign start = in_ch.valid && idle;
    assign out_ch.valid = out_valid;
    assign out_ch.data = {vel, pos};

    pvkf_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_start(start), .i_req_type(in_ch.data[0]),
        .i_out_taken(out_ch.ready), .i_status(status), .o_cmd(cmd),
        .o_idle(idle), .o_out_valid(out_valid)
    );

    pvkf_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_load(start),
        .i_meas(in_ch.data[32:1]), .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_status(status), .o_pos(pos), .o_vel(vel)
    );
endmodule
